### hw/rtl/smtc_pkg.sv
// Shared constants and the token type for the subarray mean threshold counter.
// Used by smtc_head, smtc_cell, smtc_tail and the top level. No dependencies.
package smtc_pkg;

   // Depth of the prefix store, one cell per stored prefix.
   localparam int MAX_ITEMS = 1024;

   // Field widths of the stream payload and the threshold register.
   localparam int SAMPLE_W  = 32;
   localparam int PREFIX_W  = 64;
   localparam int COUNT_W   = 20;

   // Number of stored prefixes, 0 to MAX_ITEMS.
   localparam int FILL_W    = $clog2(MAX_ITEMS + 1);
   // Cells still to compare before the write slot, 0 to MAX_ITEMS-1.
   localparam int REM_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   // Per-sample match count, 0 to MAX_ITEMS (initial zero prefix included).
   localparam int CNT_W     = $clog2(MAX_ITEMS + 2);

   // Saturation value of the running total.
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // One sample in flight along the chain of cells.
   typedef struct packed {
      logic                       valid;   // a sample occupies this slot
      logic signed [PREFIX_W-1:0] prefix;  // prefix sum of this sample
      logic [CNT_W-1:0]           cnt;     // stored prefixes <= prefix so far
      logic [REM_W-1:0]           rem;     // cells left to compare
      logic                       wr;      // prefix still has to be stored
      logic                       last;    // sample ends the sequence
      logic                       ovf;     // sequence has gone past the store
      logic                       skip;    // sample ignored, store was full
   } token_type;

endpackage

### hw/rtl/smtc_head.sv
// Entry stage: forms the prefix sum of each sample and launches its token.
// Depends on smtc_pkg for widths and the token type.
module smtc_head (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   advance,
   input  logic                                   accept,
   input  logic [smtc_pkg::SAMPLE_W-1:0]          sample,
   input  logic                                   last,
   input  logic signed [smtc_pkg::SAMPLE_W-1:0]   threshold,
   output smtc_pkg::token_type                    tok_ff
);

   logic signed [smtc_pkg::PREFIX_W-1:0] acc_ff, acc_in;
   logic [smtc_pkg::FILL_W-1:0]          fill_ff, fill_in;
   logic                                 ovf_ff, ovf_in;
   smtc_pkg::token_type                  tok_in;

   logic                                 full;
   logic signed [smtc_pkg::PREFIX_W-1:0] diff;
   logic signed [smtc_pkg::PREFIX_W-1:0] prefix;

   // Prefix sum of the new sample, relative to the threshold.
   assign full   = (fill_ff == smtc_pkg::FILL_W'(smtc_pkg::MAX_ITEMS));
   assign diff   = smtc_pkg::PREFIX_W'(signed'(sample))
                 - smtc_pkg::PREFIX_W'(threshold);
   assign prefix = acc_ff + diff;

   // Sequence state: running prefix, fill level and overflow mark.
   always_comb begin
      acc_in  = acc_ff;
      fill_in = fill_ff;
      ovf_in  = ovf_ff;
      if (accept) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            acc_in  = prefix;
            fill_in = fill_ff + smtc_pkg::FILL_W'(1);
         end
         if (last) begin
            acc_in  = '0;
            fill_in = '0;
            ovf_in  = 1'b0;
         end
      end
   end

   // Token for the chain; the initial zero prefix counts as one match.
   always_comb begin
      tok_in        = tok_ff;
      tok_in.valid  = accept;
      tok_in.prefix = prefix;
      tok_in.last   = last;
      tok_in.ovf    = ovf_ff | full;
      tok_in.skip   = full;
      if (full) begin
         tok_in.cnt = '0;
         tok_in.rem = '0;
         tok_in.wr  = 1'b0;
      end else begin
         tok_in.cnt = smtc_pkg::CNT_W'(prefix >= 0);
         tok_in.rem = fill_ff[smtc_pkg::REM_W-1:0];
         tok_in.wr  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         fill_ff <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         fill_ff <= fill_in;
         ovf_ff  <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

endmodule

### hw/rtl/smtc_cell.sv
// One cell of the prefix chain: holds one stored prefix, compares each
// passing token against it or takes the token's prefix. Depends on smtc_pkg.
module smtc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  smtc_pkg::token_type tok_i,
   output smtc_pkg::token_type tok_ff
);

   logic signed [smtc_pkg::PREFIX_W-1:0] prefix_ff, prefix_in;
   smtc_pkg::token_type                  tok_in;
   logic                                 store;

   // Compare while cells remain, otherwise store at the first free cell.
   always_comb begin
      tok_in    = tok_i;
      store     = 1'b0;
      prefix_in = prefix_ff;
      if (tok_i.valid) begin
         if (tok_i.rem != smtc_pkg::REM_W'(0)) begin
            tok_in.cnt = tok_i.cnt + smtc_pkg::CNT_W'(prefix_ff <= tok_i.prefix);
            tok_in.rem = tok_i.rem - smtc_pkg::REM_W'(1);
         end else if (tok_i.wr) begin
            store     = 1'b1;
            prefix_in = tok_i.prefix;
            tok_in.wr = 1'b0;
         end
      end
   end

   // Stored prefix, written once per sequence.
   always_ff @(posedge clock) begin
      if (advance && store) begin
         prefix_ff <= prefix_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

endmodule

### hw/rtl/smtc_tail.sv
// Exit stage: adds each token's count to the running total and holds the
// result until the downstream transfer. Depends on smtc_pkg.
module smtc_tail (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  smtc_pkg::token_type            tok_i,
   output logic                           rsp_valid_ff,
   output logic [smtc_pkg::COUNT_W-1:0]   count_ff,
   output logic                           final_ff,
   output logic                           ovf_ff
);

   logic [smtc_pkg::COUNT_W-1:0] total_ff, total_in;
   logic [smtc_pkg::COUNT_W:0]   sum;
   logic [smtc_pkg::COUNT_W-1:0] new_total;

   // Saturating add of this sample's matches.
   assign sum = {1'b0, total_ff} + (smtc_pkg::COUNT_W + 1)'(tok_i.cnt);

   always_comb begin
      if (tok_i.skip) begin
         new_total = total_ff;
      end else if (sum[smtc_pkg::COUNT_W]) begin
         new_total = smtc_pkg::COUNT_MAX;
      end else begin
         new_total = sum[smtc_pkg::COUNT_W-1:0];
      end
   end

   // The total clears after the last sample of a sequence.
   always_comb begin
      total_in = total_ff;
      if (advance && tok_i.valid) begin
         total_in = tok_i.last ? '0 : new_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         if (advance) begin
            rsp_valid_ff <= tok_i.valid;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (advance && tok_i.valid) begin
         count_ff <= new_total;
         final_ff <= tok_i.last;
         ovf_ff   <= tok_i.ovf;
      end
   end

endmodule

### hw/rtl/subarray_mean_threshold_counter.sv
// Counts, for a stream of signed samples, the contiguous subarrays whose mean
// is at least the threshold, and returns the running total for every sample.
// The block is a row of MAX_ITEMS cells, each holding one prefix sum; every
// sample becomes a token that walks the row one cell per cycle, counting
// stored prefixes at or below its own and storing itself in the first free
// cell. A new sample is taken every cycle while the result side is not stalled;
// each result passes the head register, every cell of the row and the tail
// register. A stall on the result side holds the whole row. Samples past the
// store depth are ignored and flagged; the sample marked last ends the
// sequence. Write the threshold only while no sample is in flight.
module subarray_mean_threshold_counter (
   input  logic        clock,
   input  logic        reset,
   // Sample stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] sample (signed)
   input  logic        req_tlast,    // last
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [19:0] running_count, [23:20] zero
   output logic        rsp_tlast,    // final_res
   output logic        rsp_tuser,    // overflow
   // Threshold register.
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data   // threshold (signed)
);

   logic signed [smtc_pkg::SAMPLE_W-1:0] threshold_ff, threshold_in;
   logic                                 advance;
   logic                                 accept;
   logic [smtc_pkg::COUNT_W-1:0]         count_w;
   smtc_pkg::token_type                  chain [0:smtc_pkg::MAX_ITEMS];

   // Threshold register.
   assign threshold_in = csr_wr_en ? signed'(csr_wr_data) : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // The row moves whenever the result register is free or being emptied.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;

   smtc_head u_head (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .accept    (accept),
      .sample    (req_tdata),
      .last      (req_tlast),
      .threshold (threshold_ff),
      .tok_ff    (chain[0])
   );

   // Row of prefix cells.
   for (genvar i = 0; i < smtc_pkg::MAX_ITEMS; i++) begin : g_cell
      smtc_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .tok_i   (chain[i]),
         .tok_ff  (chain[i+1])
      );
   end

   smtc_tail u_tail (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .tok_i        (chain[smtc_pkg::MAX_ITEMS]),
      .rsp_valid_ff (rsp_tvalid),
      .count_ff     (count_w),
      .final_ff     (rsp_tlast),
      .ovf_ff       (rsp_tuser)
   );

   assign rsp_tdata = {4'b0000, count_w};

   // Every counted sample has compared all earlier prefixes and been stored.
   assert property (@(posedge clock) disable iff (reset)
      chain[smtc_pkg::MAX_ITEMS].valid
         |-> (chain[smtc_pkg::MAX_ITEMS].rem == '0) && !chain[smtc_pkg::MAX_ITEMS].wr)
      else $error("token left the cell row with work outstanding");

   // An ignored sample carries no matches.
   assert property (@(posedge clock) disable iff (reset)
      chain[0].valid && chain[0].skip |-> (chain[0].cnt == '0) && !chain[0].wr)
      else $error("ignored sample carries matches or a store request");

   // An accepted sample enters the row at the next edge.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> chain[0].valid)
      else $error("accepted sample did not enter the cell row");

endmodule

### bench/subarray_mean_threshold_counter_tb.sv
// Self-checking testbench for subarray_mean_threshold_counter: random-gap sample stream,
// random result stalls, threshold sweeps, and an in-bench prefix-sum predictor.
// Depends on smtc_pkg and the subarray_mean_threshold_counter RTL only.
module subarray_mean_threshold_counter_tb;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      int sample;
      bit last;
   } sample_item_type;

   typedef struct {
      bit [smtc_pkg::COUNT_W-1:0] total;
      bit                         final_res;
      bit                         ovf;
   } total_result_type;

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [31:0]        req_tdata   = '0;
   logic               req_tlast   = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [23:0]        rsp_tdata;
   logic               rsp_tlast;
   logic               rsp_tuser;
   logic               csr_wr_en   = 1'b0;
   logic [31:0]        csr_wr_data = '0;

   // Pending samples and the totals they are expected to produce.
   sample_item_type  sample_queue[$];
   total_result_type total_queue[$];

   // Predictor copy of the threshold and the per-sequence state.
   int     m_thresh = 0;
   longint m_prefix = 0;
   longint m_store[smtc_pkg::MAX_ITEMS];
   int     m_fill   = 0;
   int     m_total  = 0;
   bit     m_ovf    = 1'b0;

   int error_count = 0;
   int issued      = 0;

   // Handshake bookkeeping for the stream drivers.
   logic req_fire   = 1'b0;
   logic rsp_fire   = 1'b0;
   int   req_gap    = 0;
   int   rsp_stall  = 0;
   bit   req_burst  = 1'b0;
   bit   rsp_burst  = 1'b0;

   subarray_mean_threshold_counter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [31:0] sample (signed)
      .req_tlast   (req_tlast),    // last
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [19:0] running_count, [23:20] zero
      .rsp_tlast   (rsp_tlast),    // final_res
      .rsp_tuser   (rsp_tuser),    // overflow
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)   // threshold (signed)
   );

   always #5 clock = ~clock;

   // Update the prefix state for one accepted sample and queue the total it yields.
   task automatic count_qualifying(input int smp, input bit lst);
      longint           p;
      int               hits;
      int               i;
      total_result_type r;
      if (m_fill >= smtc_pkg::MAX_ITEMS) begin
         // Store is full: the sample is dropped and the total repeats.
         m_ovf = 1'b1;
      end else begin
         p = m_prefix + (longint'(smp) - longint'(m_thresh));
         hits = (p >= 0) ? 1 : 0;
         for (i = 0; i < m_fill; i++) begin
            if (m_store[i] <= p) hits++;
         end
         m_store[m_fill] = p;
         m_fill++;
         m_prefix = p;
         if (hits > int'(smtc_pkg::COUNT_MAX) - m_total) m_total = int'(smtc_pkg::COUNT_MAX);
         else m_total += hits;
      end
      r.total     = m_total[smtc_pkg::COUNT_W-1:0];
      r.final_res = lst;
      r.ovf       = m_ovf;
      total_queue.insert(total_queue.size(), r);
      if (lst) begin
         m_prefix = 0;
         m_fill   = 0;
         m_total  = 0;
         m_ovf    = 1'b0;
      end
   endtask

   task automatic push_sample(input int smp, input bit lst);
      sample_item_type it;
      it.sample = smp;
      it.last   = lst;
      sample_queue.insert(sample_queue.size(), it);
      issued++;
   endtask

   // Returns once every queued sample has been taken and every total has come back.
   task automatic wait_idle();
      do @(posedge clock);
      while (sample_queue.size() != 0 || req_tvalid || total_queue.size() != 0);
   endtask

   // The register is written only while nothing is in flight.
   task automatic write_threshold(input int value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      m_thresh = value;
   endtask

   // Mostly values near the threshold so that counts vary, plus extremes and noise.
   function automatic int pick_sample(input int thr);
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom;
         default: return thr + $urandom_range(0, 40) - 20;
      endcase
   endfunction

   // Sample side: one transfer per handshake, then a random gap.
   always @(posedge clock) begin
      req_fire <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) count_qualifying(req_tdata, req_tlast);
   end

   always @(negedge clock) begin
      sample_item_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (req_tvalid && !req_fire) begin
         // Transfer still pending; hold the item.
      end else if (req_gap != 0) begin
         req_tvalid <= 1'b0;
         req_gap    <= req_gap - 1;
      end else if (sample_queue.size() != 0) begin
         item = sample_queue.pop_front();
         req_tdata  <= item.sample;
         req_tlast  <= item.last;
         req_tvalid <= 1'b1;
         if ($urandom_range(0, 40) == 0) req_burst <= !req_burst;
         req_gap <= req_burst ? 0 : $urandom_range(0, 7);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Result side: compare every transfer against the oldest expected total.
   always @(posedge clock) begin
      total_result_type want;
      rsp_fire <= rsp_tvalid && rsp_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (total_queue.size() == 0) begin
            $error("unexpected result: running_count %0d",
                   rsp_tdata[smtc_pkg::COUNT_W-1:0]);
            error_count++;
         end else begin
            want = total_queue.pop_front();
            if (rsp_tdata[smtc_pkg::COUNT_W-1:0] !== want.total) begin
               $error("running_count: expected %0d, got %0d", want.total,
                      rsp_tdata[smtc_pkg::COUNT_W-1:0]);
               error_count++;
            end
            if (rsp_tlast !== want.final_res) begin
               $error("final_res: expected %0d, got %0d", want.final_res, rsp_tlast);
               error_count++;
            end
            if (rsp_tuser !== want.ovf) begin
               $error("overflow: expected %0d, got %0d", want.ovf, rsp_tuser);
               error_count++;
            end
         end
      end
   end

   // Ready goes low for a random stall after each transfer, with burst stretches.
   always @(negedge clock) begin
      int n;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else if (rsp_fire) begin
         if ($urandom_range(0, 40) == 0) rsp_burst <= !rsp_burst;
         n = rsp_burst ? 0 : $urandom_range(0, 7);
         rsp_tready <= (n == 0);
         rsp_stall  <= (n == 0) ? 0 : n - 1;
      end else if (rsp_stall != 0) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      int thr;
      int phase;
      int n;
      int nseq;
      int len;
      int s;
      int k;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default threshold: ties with the initial zero prefix and full-scale samples.
      write_threshold(0);
      push_sample(0, 1'b0);
      push_sample(32'h7FFF_FFFF, 1'b0);
      push_sample(32'h8000_0000, 1'b0);
      push_sample(-1, 1'b0);
      push_sample(1, 1'b0);
      push_sample(0, 1'b1);
      wait_idle();

      // Largest threshold against extreme samples.
      write_threshold(32'h7FFF_FFFF);
      push_sample(32'h8000_0000, 1'b0);
      push_sample(32'h7FFF_FFFF, 1'b0);
      push_sample(32'h8000_0000, 1'b1);
      wait_idle();

      // Smallest threshold: every subarray qualifies.
      write_threshold(32'h8000_0000);
      push_sample(32'h7FFF_FFFF, 1'b0);
      push_sample(32'h7FFF_FFFF, 1'b0);
      push_sample(32'h8000_0000, 1'b1);
      wait_idle();

      // Mean exactly at the threshold, then a threshold change mid-sequence.
      write_threshold(5);
      push_sample(5, 1'b0);
      push_sample(4, 1'b0);
      push_sample(6, 1'b0);
      wait_idle();
      write_threshold(-3);
      push_sample(-3, 1'b0);
      push_sample(-10, 1'b0);
      push_sample(2, 1'b1);
      wait_idle();

      // Random phases; one of them runs a sequence past the store depth.
      phase = 0;
      while (issued < 1950) begin
         case ($urandom_range(0, 5))
            0:       thr = 0;
            1:       thr = 32'h7FFF_FFFF;
            2:       thr = 32'h8000_0000;
            3:       thr = $urandom;
            default: thr = $urandom_range(0, 200) - 100;
         endcase
         write_threshold(thr);
         if (phase == 2) begin
            n = smtc_pkg::MAX_ITEMS + $urandom_range(1, 16);
            for (k = 0; k < n; k++) push_sample(pick_sample(thr), k == n - 1);
         end else begin
            nseq = $urandom_range(1, 4);
            for (s = 0; s < nseq; s++) begin
               len = $urandom_range(1, 40);
               // The final sequence of a phase is sometimes left open across the write.
               for (k = 0; k < len; k++) begin
                  push_sample(pick_sample(thr),
                              k == len - 1 && (s < nseq - 1 || $urandom_range(0, 3) != 0));
               end
            end
         end
         wait_idle();
         phase++;
      end

      // Catch any stray result after the last expected one.
      repeat (smtc_pkg::MAX_ITEMS + 100) @(posedge clock);
      if (error_count == 0) begin
         $display("subarray_mean_threshold_counter_tb: clean");
      end else begin
         $display("subarray_mean_threshold_counter_tb: errors");
      end
      $finish;
   end

   // Hard limit well beyond the slowest legal run.
   initial begin
      #10_000_000;
      $display("subarray_mean_threshold_counter_tb: errors");
      $finish;
   end

endmodule
